// ----- rtl/utcc_pkg.sv -----
// -----------------------------------------------------------------------------
// utcc_pkg: shared types, constants and calendar functions
// Leap-year test, year and month lengths in seconds, and the structs that
// pass between the sequencer and the shared add/subtract unit.
// -----------------------------------------------------------------------------
package utcc_pkg;

   localparam int unsigned WORD_W = 32;

   localparam logic [11:0]       EPOCH_YEAR      = 12'd1970;
   localparam logic [3:0]        MONTHS_PER_YEAR = 4'd12;
   localparam logic [WORD_W-1:0] SEC_PER_MIN     = 32'd60;
   localparam logic [WORD_W-1:0] SEC_PER_HOUR    = 32'd3600;
   localparam logic [WORD_W-1:0] SEC_PER_DAY     = 32'd86400;
   localparam logic [WORD_W-1:0] SEC_PER_YEAR    = 32'd31536000;
   localparam logic [WORD_W-1:0] SEC_PER_LYEAR   = 32'd31622400;

   // floor(y / 100) for 12-bit y by reciprocal multiply
   localparam logic [12:0] RECIP_100 = 13'd5243;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] res;
      logic              ok;
   } alu_rsp_type;

   function automatic logic leap_year(input logic [11:0] y);
      logic [24:0] prod;
      logic [5:0]  q;
      logic [11:0] r;
      prod = y * RECIP_100;
      q    = prod[24:19];
      r    = y - ({6'd0, q} * 12'd100);
      return ((y[1:0] == 2'd0) && (r != 12'd0)) || ((r == 12'd0) && (q[1:0] == 2'd0));
   endfunction

   function automatic logic [WORD_W-1:0] year_sec(input logic leap);
      return leap ? SEC_PER_LYEAR : SEC_PER_YEAR;
   endfunction

   function automatic logic [WORD_W-1:0] month_sec(input logic [3:0] m, input logic leap);
      logic [WORD_W-1:0] r;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 32'd2678400;
         4'd4, 4'd6, 4'd9, 4'd11:                   r = 32'd2592000;
         4'd2:    r = leap ? 32'd2505600 : 32'd2419200;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/unix_time_calendar_converter_top.sv -----
// -----------------------------------------------------------------------------
// unix_time_calendar_converter_top: Unix seconds <-> Gregorian UTC date/time
// Command channel in, strobed result beat out, one shared add/subtract unit.
// -----------------------------------------------------------------------------
// usage:
//   a request beat is taken when start is high and busy is low. req_command
//   low converts req_in_year .. req_in_second to seconds (mod 2^32), high
//   converts req_in_epoch_seconds to year, month, day, hour, minute, second.
//   the result is on the rsp_ ports for one cycle with rsp_valid high; the
//   receiver cannot stall, so the beat is lost if not captured then.
// conversion:
//   every step is one add or subtract on the shared 32-bit unit per cycle.
//   to seconds: one add step per whole year from 1970 and per whole month,
//   then one each for the days, hours, minutes and seconds.
//   to date: one subtract step per whole year, month, day, hour and
//   minute peeled off.
//   busy is high for the whole conversion; one item at a time.
// reset:
//   synchronous, active high; returns to idle and drops rsp_valid.
// -----------------------------------------------------------------------------
module unix_time_calendar_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [11:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [4:0]  req_in_hour,
   input  logic [5:0]  req_in_minute,
   input  logic [5:0]  req_in_second,
   input  logic [31:0] req_in_epoch_seconds,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_epoch_seconds,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second
);

   utcc_pkg::alu_req_type alu_req;
   utcc_pkg::alu_rsp_type alu_rsp;

   utcc_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   utcc_seq u_seq (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_in_year           (req_in_year),
      .req_in_month          (req_in_month),
      .req_in_day            (req_in_day),
      .req_in_hour           (req_in_hour),
      .req_in_minute         (req_in_minute),
      .req_in_second         (req_in_second),
      .req_in_epoch_seconds  (req_in_epoch_seconds),
      .alu_req               (alu_req),
      .alu_rsp               (alu_rsp),
      .rsp_valid             (rsp_valid),
      .rsp_out_epoch_seconds (rsp_out_epoch_seconds),
      .rsp_out_year          (rsp_out_year),
      .rsp_out_month         (rsp_out_month),
      .rsp_out_day           (rsp_out_day),
      .rsp_out_hour          (rsp_out_hour),
      .rsp_out_minute        (rsp_out_minute),
      .rsp_out_second        (rsp_out_second)
   );

endmodule

// ----- rtl/utcc_alu.sv -----
// -----------------------------------------------------------------------------
// utcc_alu: shared 32-bit add/subtract unit
// Adds for accumulation, or subtracts and flags whether the operand fits.
// -----------------------------------------------------------------------------
module utcc_alu (
   input  utcc_pkg::alu_req_type req,
   output utcc_pkg::alu_rsp_type rsp
);

   logic [utcc_pkg::WORD_W:0] diff;
   logic [utcc_pkg::WORD_W:0] sum;

   assign diff = {1'b0, req.a} - {1'b0, req.b};
   assign sum  = {1'b0, req.a} + {1'b0, req.b};

   always_comb begin
      if (req.sub) begin
         rsp.res = diff[utcc_pkg::WORD_W-1:0];
         rsp.ok  = ~diff[utcc_pkg::WORD_W];
      end else begin
         rsp.res = sum[utcc_pkg::WORD_W-1:0];
         rsp.ok  = 1'b1;
      end
   end

endmodule

// ----- rtl/utcc_seq.sv -----
// -----------------------------------------------------------------------------
// utcc_seq: conversion sequencer
// Steps through years, months, days, hours and minutes, one add or
// subtract on the shared unit per cycle, and registers the result beat.
// -----------------------------------------------------------------------------
module utcc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [11:0]           req_in_year,
   input  logic [3:0]            req_in_month,
   input  logic [4:0]            req_in_day,
   input  logic [4:0]            req_in_hour,
   input  logic [5:0]            req_in_minute,
   input  logic [5:0]            req_in_second,
   input  logic [31:0]           req_in_epoch_seconds,
   output utcc_pkg::alu_req_type alu_req,
   input  utcc_pkg::alu_rsp_type alu_rsp,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_out_epoch_seconds,
   output logic [11:0]           rsp_out_year,
   output logic [3:0]            rsp_out_month,
   output logic [4:0]            rsp_out_day,
   output logic [4:0]            rsp_out_hour,
   output logic [5:0]            rsp_out_minute,
   output logic [5:0]            rsp_out_second
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MONTHS,
      ST_DAYS,
      ST_HOURS,
      ST_MINUTES,
      ST_SECONDS
   } state_type;

   state_type   state_ff;
   logic        cmd_ff;
   logic [11:0] in_year_ff;
   logic [3:0]  in_month_ff;
   logic [4:0]  in_day_ff;
   logic [4:0]  in_hour_ff;
   logic [5:0]  in_minute_ff;
   logic [5:0]  in_second_ff;
   logic [31:0] acc_ff;
   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic        leap_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic        rsp_valid_ff;
   logic [31:0] out_epoch_ff;
   logic [11:0] out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_day_ff;
   logic [4:0]  out_hour_ff;
   logic [5:0]  out_minute_ff;
   logic [5:0]  out_second_ff;

   logic [31:0] day_m1;
   logic [31:0] operand;
   logic [11:0] year_inc;

   assign day_m1   = {27'd0, in_day_ff} - 32'd1;
   assign year_inc = year_ff + 12'd1;

   // operand for the shared unit
   always_comb begin
      unique case (state_ff)
         ST_YEARS:   operand = utcc_pkg::year_sec(leap_ff);
         ST_MONTHS:  operand = utcc_pkg::month_sec(month_ff, leap_ff);
         ST_DAYS:    operand = cmd_ff ? utcc_pkg::SEC_PER_DAY
                                      : day_m1 * utcc_pkg::SEC_PER_DAY;
         ST_HOURS:   operand = cmd_ff ? utcc_pkg::SEC_PER_HOUR
                                      : {27'd0, in_hour_ff} * utcc_pkg::SEC_PER_HOUR;
         ST_MINUTES: operand = cmd_ff ? utcc_pkg::SEC_PER_MIN
                                      : {26'd0, in_minute_ff} * utcc_pkg::SEC_PER_MIN;
         ST_SECONDS: operand = {26'd0, in_second_ff};
         default:    operand = '0;
      endcase
   end

   assign alu_req.a   = acc_ff;
   assign alu_req.b   = operand;
   assign alu_req.sub = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff       <= req_command;
                  in_year_ff   <= req_in_year;
                  in_month_ff  <= req_in_month;
                  in_day_ff    <= req_in_day;
                  in_hour_ff   <= req_in_hour;
                  in_minute_ff <= req_in_minute;
                  in_second_ff <= req_in_second;
                  acc_ff       <= req_command ? req_in_epoch_seconds : '0;
                  year_ff      <= utcc_pkg::EPOCH_YEAR;
                  month_ff     <= 4'd1;
                  leap_ff      <= utcc_pkg::leap_year(utcc_pkg::EPOCH_YEAR);
                  day_ff       <= 5'd1;
                  hour_ff      <= '0;
                  minute_ff    <= '0;
                  state_ff     <= ST_YEARS;
               end
            end
            ST_YEARS: begin
               if (cmd_ff ? alu_rsp.ok : (year_ff < in_year_ff)) begin
                  acc_ff  <= alu_rsp.res;
                  year_ff <= year_inc;
                  leap_ff <= utcc_pkg::leap_year(year_inc);
               end else begin
                  if (!cmd_ff) begin
                     leap_ff <= utcc_pkg::leap_year(in_year_ff);
                  end
                  state_ff <= ST_MONTHS;
               end
            end
            ST_MONTHS: begin
               if (cmd_ff ? ((month_ff < utcc_pkg::MONTHS_PER_YEAR) && alu_rsp.ok)
                          : (month_ff < in_month_ff)) begin
                  acc_ff   <= alu_rsp.res;
                  month_ff <= month_ff + 4'd1;
               end else begin
                  state_ff <= ST_DAYS;
               end
            end
            ST_DAYS: begin
               if (!cmd_ff) begin
                  acc_ff   <= alu_rsp.res;
                  state_ff <= ST_HOURS;
               end else if (alu_rsp.ok) begin
                  acc_ff <= alu_rsp.res;
                  day_ff <= day_ff + 5'd1;
               end else begin
                  state_ff <= ST_HOURS;
               end
            end
            ST_HOURS: begin
               if (!cmd_ff) begin
                  acc_ff   <= alu_rsp.res;
                  state_ff <= ST_MINUTES;
               end else if (alu_rsp.ok) begin
                  acc_ff  <= alu_rsp.res;
                  hour_ff <= hour_ff + 5'd1;
               end else begin
                  state_ff <= ST_MINUTES;
               end
            end
            ST_MINUTES: begin
               if (!cmd_ff) begin
                  acc_ff   <= alu_rsp.res;
                  state_ff <= ST_SECONDS;
               end else if (alu_rsp.ok) begin
                  acc_ff    <= alu_rsp.res;
                  minute_ff <= minute_ff + 6'd1;
               end else begin
                  // date beat
                  out_epoch_ff  <= '0;
                  out_year_ff   <= year_ff;
                  out_month_ff  <= month_ff;
                  out_day_ff    <= day_ff;
                  out_hour_ff   <= hour_ff;
                  out_minute_ff <= minute_ff;
                  out_second_ff <= acc_ff[5:0];
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_SECONDS: begin
               // seconds beat
               out_epoch_ff  <= alu_rsp.res;
               out_year_ff   <= utcc_pkg::EPOCH_YEAR;
               out_month_ff  <= 4'd1;
               out_day_ff    <= 5'd1;
               out_hour_ff   <= '0;
               out_minute_ff <= '0;
               out_second_ff <= '0;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_epoch_seconds = out_epoch_ff;
   assign rsp_out_year          = out_year_ff;
   assign rsp_out_month         = out_month_ff;
   assign rsp_out_day           = out_day_ff;
   assign rsp_out_hour          = out_hour_ff;
   assign rsp_out_minute        = out_minute_ff;
   assign rsp_out_second        = out_second_ff;

endmodule
